// ===== hdl/gne_pkg.sv =====
// shared types, codes and helper functions of the grid neighbour expansion block
`timescale 1ns / 1ps

package gne_pkg;

  localparam int unsigned GNE_GRID_SIDE = 64;
  localparam int unsigned GNE_COORD_W   = 6;
  localparam int unsigned GNE_TYPE_W    = 3;
  localparam int unsigned GNE_MASK_W    = 5;
  localparam int unsigned GNE_NB_COUNT  = 8;

  typedef enum logic [2:0] {
    CMD_EXPAND = 3'd0,
    CMD_START  = 3'd1,
    CMD_END    = 3'd2,
    CMD_BLOCK  = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_PATH   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    CT_FREE    = 3'd0,
    CT_BLOCKED = 3'd1,
    CT_VISITED = 3'd2,
    CT_START   = 3'd3,
    CT_END     = 3'd4,
    CT_PATH    = 3'd5
  } cell_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT,
    ST_UNMARK,
    ST_WRITE,
    ST_SWEEP,
    ST_SWEEP_END
  } state_e;

  // clear mask bit positions
  localparam int unsigned MASK_PATH    = 0;
  localparam int unsigned MASK_VISITED = 1;
  localparam int unsigned MASK_BLOCKED = 2;
  localparam int unsigned MASK_START   = 3;
  localparam int unsigned MASK_END     = 4;

  // column offset code of neighbour k (0: -1, 1: 0, 2: +1), rows outer
  function automatic logic [1:0] nb_dx(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0, 3'd3, 3'd5: r = 2'd0;
      3'd1, 3'd6:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nb_dy(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // blocked, visited and start cells are never expanded into
  function automatic logic admissible(input logic [GNE_TYPE_W-1:0] t);
    return !(t == CT_BLOCKED || t == CT_VISITED || t == CT_START);
  endfunction

  function automatic logic clear_hit(input logic [GNE_TYPE_W-1:0] t,
                                     input logic [GNE_MASK_W-1:0] mask);
    return (t == CT_PATH    && mask[MASK_PATH])    ||
           (t == CT_VISITED && mask[MASK_VISITED]) ||
           (t == CT_BLOCKED && mask[MASK_BLOCKED]) ||
           (t == CT_START   && mask[MASK_START])   ||
           (t == CT_END     && mask[MASK_END]);
  endfunction

endpackage

// ===== hdl/gne_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module gne_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/grid_neighbour_expansion.sv =====
// Grid of cell types with 8-neighbour expansion. All cell types live in one memory of
// min(GRID_SIDE,64)^2 entries (4096 by default) with one write and one registered read
// port, and every command is a short sequence of reads and writes on it. After reset a
// clearing pass writes every cell free, one per cycle, while in_stall_o stays high. An
// expand request reads its eight neighbours through the read port, then issues one
// result per cycle (at least one) as long as the output register is taken; each
// admitted neighbour is written visited as its result is issued. An expand on a cell
// outside the grid skips the reads and issues its empty result at once. Place start and
// place end write the cell, first freeing an earlier marker if one is present; block
// and mark path write the cell; on a cell outside the grid these four write nothing.
// A clear request sweeps the whole memory, reading each cell and writing it free when
// the clear mask selects its type. A new request is taken once the block is idle again;
// after an expand, that is as soon as its last result sits in the output register.
`timescale 1ns / 1ps

module grid_neighbour_expansion #(
  parameter int unsigned GRID_SIDE = gne_pkg::GNE_GRID_SIDE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      command_i,
  input  logic [gne_pkg::GNE_COORD_W-1:0] cell_x_i,
  input  logic [gne_pkg::GNE_COORD_W-1:0] cell_y_i,
  input  logic [gne_pkg::GNE_MASK_W-1:0]  clear_mask_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [gne_pkg::GNE_COORD_W-1:0] neighbour_x_o,
  output logic [gne_pkg::GNE_COORD_W-1:0] neighbour_y_o,
  output logic                            last_o
);

  import gne_pkg::*;

  localparam int unsigned SideUsed  = (GRID_SIDE < 64) ? GRID_SIDE : 64;
  localparam int unsigned CellCount = SideUsed * SideUsed;
  localparam int unsigned AW        = $clog2(CellCount);
  localparam logic [AW-1:0] LastAddr = AW'(CellCount - 1);
  localparam logic [GNE_COORD_W:0] SideLim = (GNE_COORD_W + 1)'(SideUsed);

  typedef struct packed {
    logic                   in_grid;
    logic [GNE_COORD_W-1:0] x;
    logic [GNE_COORD_W-1:0] y;
  } nb_t;

  function automatic logic [AW-1:0] cell_addr(input logic [GNE_COORD_W-1:0] x,
                                              input logic [GNE_COORD_W-1:0] y);
    logic [13:0] prod;
    prod = 14'(y) * 14'(SideUsed) + 14'(x);
    return prod[AW-1:0];
  endfunction

  function automatic nb_t neighbour(input logic [2:0] k,
                                    input logic [GNE_COORD_W-1:0] cx,
                                    input logic [GNE_COORD_W-1:0] cy);
    logic [GNE_COORD_W:0] nx;
    logic [GNE_COORD_W:0] ny;
    nb_t r;
    // negative coordinates wrap to large values and fall outside the grid
    nx = {1'b0, cx} + (GNE_COORD_W + 1)'(nb_dx(k)) - (GNE_COORD_W + 1)'(1);
    ny = {1'b0, cy} + (GNE_COORD_W + 1)'(nb_dy(k)) - (GNE_COORD_W + 1)'(1);
    r.in_grid = (nx < SideLim) && (ny < SideLim);
    r.x = nx[GNE_COORD_W-1:0];
    r.y = ny[GNE_COORD_W-1:0];
    return r;
  endfunction

  state_e state_q, state_d;

  logic                   accept;
  logic                   centre_in;
  cmd_e                   cmd_q;
  logic [GNE_COORD_W-1:0] cx_q, cy_q;
  logic [GNE_MASK_W-1:0]  mask_q;
  logic [AW-1:0]          cur_addr;

  logic [AW-1:0] cnt_q, cnt_d;
  logic [2:0]    k_q, k_d;
  logic          rd_valid_q, rd_valid_d;
  logic [2:0]    rd_k_q, rd_k_d;
  logic          rd_in_q, rd_in_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [GNE_NB_COUNT-1:0] adm_q, adm_d;

  logic          start_present_q, end_present_q;
  logic [AW-1:0] start_cell_q, end_cell_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [GNE_TYPE_W-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [GNE_TYPE_W-1:0] ram_rdata;

  logic                   out_valid_q;
  logic                   found_q, last_q;
  logic [GNE_COORD_W-1:0] nx_q, ny_q;
  logic                   emit_go;

  nb_t                     scan_nb;
  nb_t                     emit_nb;
  logic [2:0]              emit_k;
  logic [GNE_NB_COUNT-1:0] adm_rest;

  gne_ram #(
    .WIDTH(GNE_TYPE_W),
    .DEPTH(CellCount),
    .AW   (AW)
  ) u_grid_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign centre_in  = ({1'b0, cell_x_i} < SideLim) && ({1'b0, cell_y_i} < SideLim);
  assign cur_addr   = cell_addr(cx_q, cy_q);
  assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign scan_nb    = neighbour(k_q, cx_q, cy_q);

  // lowest admitted neighbour goes out first
  always_comb begin
    emit_k = 3'd0;
    for (int i = GNE_NB_COUNT - 1; i >= 0; i--) begin
      if (adm_q[i]) begin
        emit_k = 3'(i);
      end
    end
  end

  assign emit_nb  = neighbour(emit_k, cx_q, cy_q);
  assign adm_rest = adm_q & ~(GNE_NB_COUNT'(1) << emit_k);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (cnt_q == LastAddr) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_EXPAND: state_d = centre_in ? ST_SCAN : ST_EMIT;
            CMD_CLEAR:  state_d = ST_SWEEP;
            CMD_START: begin
              if (centre_in) state_d = start_present_q ? ST_UNMARK : ST_WRITE;
            end
            CMD_END: begin
              if (centre_in) state_d = end_present_q ? ST_UNMARK : ST_WRITE;
            end
            CMD_BLOCK, CMD_PATH: begin
              if (centre_in) state_d = ST_WRITE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (k_q == 3'(GNE_NB_COUNT - 1)) state_d = ST_SCAN_END;
      end
      ST_SCAN_END: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go && adm_rest == '0) state_d = ST_IDLE;
      end
      ST_UNMARK: state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_IDLE;
      ST_SWEEP: begin
        if (cnt_q == LastAddr) state_d = ST_SWEEP_END;
      end
      ST_SWEEP_END: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory ports and sequencing counters
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = cur_addr;
    ram_wdata  = CT_FREE;
    ram_raddr  = '0;
    cnt_d      = cnt_q;
    k_d        = k_q;
    rd_valid_d = 1'b0;
    rd_k_d     = rd_k_q;
    rd_in_d    = rd_in_q;
    rd_addr_d  = rd_addr_q;
    adm_d      = adm_q;
    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = CT_FREE;
        cnt_d     = cnt_q + AW'(1);
      end
      ST_IDLE: begin
        cnt_d = '0;
        k_d   = '0;
        adm_d = '0;
      end
      ST_SCAN, ST_SCAN_END: begin
        if (state_q == ST_SCAN) begin
          ram_raddr  = scan_nb.in_grid ? cell_addr(scan_nb.x, scan_nb.y) : '0;
          rd_valid_d = 1'b1;
          rd_k_d     = k_q;
          rd_in_d    = scan_nb.in_grid;
          k_d        = k_q + 3'd1;
        end
        if (rd_valid_q) begin
          adm_d[rd_k_q] = rd_in_q && admissible(ram_rdata);
        end
      end
      ST_EMIT: begin
        if (emit_go && adm_q != '0) begin
          ram_we        = 1'b1;
          ram_waddr     = cell_addr(emit_nb.x, emit_nb.y);
          ram_wdata     = CT_VISITED;
          adm_d[emit_k] = 1'b0;
        end
      end
      ST_UNMARK: begin
        ram_we    = 1'b1;
        ram_waddr = (cmd_q == CMD_START) ? start_cell_q : end_cell_q;
        ram_wdata = CT_FREE;
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        case (cmd_q)
          CMD_START: ram_wdata = CT_START;
          CMD_END:   ram_wdata = CT_END;
          CMD_BLOCK: ram_wdata = CT_BLOCKED;
          default:   ram_wdata = CT_PATH;
        endcase
      end
      ST_SWEEP, ST_SWEEP_END: begin
        if (state_q == ST_SWEEP) begin
          ram_raddr  = cnt_q;
          rd_valid_d = 1'b1;
          rd_addr_d  = cnt_q;
          cnt_d      = cnt_q + AW'(1);
        end
        // write back the cell read last cycle
        if (rd_valid_q && clear_hit(ram_rdata, mask_q)) begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_q;
          ram_wdata = CT_FREE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      cnt_q      <= '0;
      k_q        <= '0;
      rd_valid_q <= 1'b0;
      adm_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      k_q        <= k_d;
      rd_valid_q <= rd_valid_d;
      adm_q      <= adm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_k_q    <= rd_k_d;
    rd_in_q   <= rd_in_d;
    rd_addr_q <= rd_addr_d;
    if (accept) begin
      cmd_q  <= cmd_e'(command_i);
      cx_q   <= cell_x_i;
      cy_q   <= cell_y_i;
      mask_q <= clear_mask_i;
    end
  end

  // start and end markers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_present_q <= 1'b0;
      start_cell_q    <= '0;
      end_present_q   <= 1'b0;
      end_cell_q      <= '0;
    end else if (accept && command_i == CMD_CLEAR) begin
      if (clear_mask_i[MASK_START]) begin
        start_present_q <= 1'b0;
        start_cell_q    <= '0;
      end
      if (clear_mask_i[MASK_END]) begin
        end_present_q <= 1'b0;
        end_cell_q    <= '0;
      end
    end else if (state_q == ST_WRITE) begin
      if (cmd_q == CMD_START) begin
        start_present_q <= 1'b1;
        start_cell_q    <= cur_addr;
      end
      if (cmd_q == CMD_END) begin
        end_present_q <= 1'b1;
        end_cell_q    <= cur_addr;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      if (adm_q == '0) begin
        found_q <= 1'b0;
        nx_q    <= '0;
        ny_q    <= '0;
        last_q  <= 1'b1;
      end else begin
        found_q <= 1'b1;
        nx_q    <= emit_nb.x;
        ny_q    <= emit_nb.y;
        last_q  <= (adm_rest == '0);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign neighbour_x_o = nx_q;
  assign neighbour_y_o = ny_q;
  assign last_o        = last_q;

endmodule

// ===== hdl/gne_checker.sv =====
// port-level checks of the grid neighbour expansion block and their binding
`timescale 1ns / 1ps

module gne_checker #(
  parameter int unsigned GRID_SIDE = gne_pkg::GNE_GRID_SIDE
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [2:0]                      command_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            found_o,
  input logic [gne_pkg::GNE_COORD_W-1:0] neighbour_x_o,
  input logic [gne_pkg::GNE_COORD_W-1:0] neighbour_y_o,
  input logic                            last_o
);

  import gne_pkg::*;

  localparam int unsigned SideUsed = (GRID_SIDE < 64) ? GRID_SIDE : 64;
  localparam logic [GNE_COORD_W:0] SideLim = (GNE_COORD_W + 1)'(SideUsed);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) &&
      $stable(neighbour_x_o) && $stable(neighbour_y_o) && $stable(last_o))
    else $error("stalled result changed");

  // an empty result is all zero and ends its run
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o && neighbour_x_o == '0 && neighbour_y_o == '0)
    else $error("malformed empty result");

  // admitted neighbours lie inside the grid
  a_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |->
      ({1'b0, neighbour_x_o} < SideLim) && ({1'b0, neighbour_y_o} < SideLim))
    else $error("neighbour outside grid");

  // an expand request keeps the block busy while its results are produced
  a_expand_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i == CMD_EXPAND |=> in_stall_o)
    else $error("expand request did not occupy the block");

endmodule

bind grid_neighbour_expansion gne_checker #(
  .GRID_SIDE(GRID_SIDE)
) u_gne_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .command_i    (command_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .found_o      (found_o),
  .neighbour_x_o(neighbour_x_o),
  .neighbour_y_o(neighbour_y_o),
  .last_o       (last_o)
);
